// ===== src/lmc_pkg.sv =====
`timescale 1ns / 1ps

package lmc_pkg;

    // shared multiplier operand widths
    localparam int MUL_A_W = 19;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_MA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SENSE_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_P_GAIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_I_GAIN       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_D_GAIN       = 3'd6;

    // control laws
    localparam logic [1:0] MODE_BANG = 2'd0;
    localparam logic [1:0] MODE_INCR = 2'd1;
    localparam logic [1:0] MODE_PROP = 2'd2;
    localparam logic [1:0] MODE_PID  = 2'd3;

    // operand selection for the shared multiplier
    typedef enum logic [1:0] {
        OP_MEAS = 2'd0,
        OP_P    = 2'd1,
        OP_I    = 2'd2,
        OP_D    = 2'd3
    } op_sel_t;

    // per-cycle control from the sequencer to the datapath
    typedef struct packed {
        op_sel_t sel;
        logic    mul_en;
        logic    law_en;
        logic    acc_load;
        logic    acc_add;
        logic    acc_sub;
        logic    fin;
    } ctl_t;

endpackage

// ===== src/led_current_multimode_controller_unit.sv =====
`timescale 1ns / 1ps

// led current controller: one control step per current-sense sample
//
// input channel carries adc_sample (in_valid / in_stall); output channel
// carries the new duty and the scaled current measured_ma (out_valid /
// out_stall). a beat moves when valid is high and stall is low. the
// plain configuration port (cfg_we, cfg_index, cfg_data) ignores unknown
// indexes; the user must write it only while the block is idle (unchecked).
//
// one sample is in flight at a time. a single 19x17 multiplier is reused:
// once for the sense scaling and, in pid mode, three more times for the
// p, i and d terms. bang-bang, incremental and proportional steps run
// multiply, law and saturate; pid adds p, i, d multiplies and the d
// accumulate; the result is registered as the saturate state is left.
//
// the output register frees the input side: a new sample is taken while
// a result still waits. if the receiver stalls, the next result waits in
// the final step until the held one leaves.
// reset clears the state (duty, integrator, last measurement) to zero
// and loads the register defaults.
module led_current_multimode_controller_unit
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // sample beats
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [15:0]                         adc_sample,
    // result beats
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [14:0]                         duty,
    output logic [15:0]                         measured_ma,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [lmc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lmc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import lmc_pkg::*;

    localparam int ACC_W = PROD_W + 1;
    localparam logic signed [MUL_A_W-1:0] INC_STEP = MUL_A_W'(10);

    // configuration registers
    logic [1:0]  mode_reg;
    logic [11:0] setpoint_reg;
    logic [14:0] limit_reg;
    logic [15:0] sense_gain_reg;
    logic [15:0] p_gain_reg;
    logic [15:0] i_gain_reg;
    logic [15:0] d_gain_reg;

    // controller state
    logic [14:0]        duty_state_reg;
    logic signed [15:0] integ_reg;
    logic [15:0]        last_reg;

    // per-sample working registers
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [15:0]            meas_reg;
    logic signed [17:0]     err_reg;
    logic [14:0]            law_duty_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // output register
    logic        out_valid_reg;
    logic [14:0] out_duty_reg;
    logic [15:0] out_meas_reg;

    ctl_t ctl;
    logic idle;
    logic in_beat;
    logic out_free;
    logic pid_mode;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    function automatic logic [14:0] clamp_duty(input logic signed [MUL_A_W-1:0] v,
                                               input logic [14:0] lim);
        logic [14:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > $signed({4'd0, lim}))
        begin
            r = lim;
        end
        else
        begin
            r = v[14:0];
        end
        return r;
    endfunction

    assign pid_mode = (mode_reg == MODE_PID);
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !idle;
    assign in_beat  = in_valid && idle;

    lmc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .pid_mode (pid_mode),
        .out_free (out_free),
        .ctl      (ctl),
        .idle     (idle)
    );

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_BANG;
            setpoint_reg   <= '0;
            limit_reg      <= 15'd32767;
            sense_gain_reg <= 16'd65535;
            p_gain_reg     <= 16'd351;
            i_gain_reg     <= 16'd593;
            d_gain_reg     <= 16'd259;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CONTROL_MODE: mode_reg       <= cfg_data[1:0];
                REG_SETPOINT_MA:  setpoint_reg   <= cfg_data[11:0];
                REG_DUTY_LIMIT:   limit_reg      <= cfg_data[14:0];
                REG_SENSE_GAIN:   sense_gain_reg <= cfg_data;
                REG_P_GAIN:       p_gain_reg     <= cfg_data;
                REG_I_GAIN:       i_gain_reg     <= cfg_data;
                REG_D_GAIN:       d_gain_reg     <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // shared multiplier and its operand mux
    // ---------------------------------------------------------------
    logic signed [16:0] meas_diff;
    assign meas_diff = $signed({1'b0, meas_reg}) - $signed({1'b0, last_reg});

    always_comb
    begin
        case (ctl.sel)
            OP_MEAS:
            begin
                mul_a = MUL_A_W'(sample_reg);
                mul_b = {1'b0, sense_gain_reg};
            end
            OP_P:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = {1'b0, p_gain_reg};
            end
            OP_I:
            begin
                mul_a = MUL_A_W'(integ_reg);
                mul_b = {1'b0, i_gain_reg};
            end
            OP_D:
            begin
                mul_a = MUL_A_W'(meas_diff);
                mul_b = {1'b0, d_gain_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    lmc_mul u_mul
    (
        .clk  (clk),
        .en   (ctl.mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // ---------------------------------------------------------------
    // control law step: error, simple laws, integrator update
    // ---------------------------------------------------------------
    logic [15:0]               meas_w;
    logic signed [17:0]        err_w;
    logic                      below_sp;
    logic signed [MUL_A_W-1:0] duty_ext;
    logic signed [MUL_A_W-1:0] lim_ext;
    logic signed [MUL_A_W-1:0] integ_sum;
    logic signed [15:0]        integ_w;
    logic [14:0]               law_duty_w;

    assign meas_w   = prod[31:16];
    assign err_w    = $signed({6'd0, setpoint_reg}) - $signed({2'd0, meas_w});
    assign below_sp = (meas_w < {4'd0, setpoint_reg});
    assign duty_ext = $signed({4'd0, duty_state_reg});
    assign lim_ext  = $signed({4'd0, limit_reg});
    assign integ_sum = MUL_A_W'(integ_reg) + MUL_A_W'(err_w);

    always_comb
    begin
        if (integ_sum > lim_ext)
        begin
            integ_w = lim_ext[15:0];
        end
        else if (integ_sum < -lim_ext)
        begin
            integ_w = 16'(-lim_ext);
        end
        else
        begin
            integ_w = integ_sum[15:0];
        end
    end

    always_comb
    begin
        case (mode_reg)
            MODE_BANG: law_duty_w = below_sp ? limit_reg : '0;
            MODE_INCR: law_duty_w = clamp_duty(below_sp ? duty_ext + INC_STEP
                                                        : duty_ext - INC_STEP,
                                               limit_reg);
            MODE_PROP: law_duty_w = clamp_duty(duty_ext + MUL_A_W'(err_w), limit_reg);
            default:   law_duty_w = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // pid accumulation and saturation
    // ---------------------------------------------------------------
    logic signed [ACC_W-1:0] prod_ext;
    logic [ACC_W-9:0]        acc_shr;
    logic [14:0]             pid_duty_w;
    logic [14:0]             sat_duty_w;

    assign prod_ext = ACC_W'(prod);
    assign acc_shr  = acc_reg[ACC_W-1:8];

    always_comb
    begin
        if (acc_reg < 0)
        begin
            pid_duty_w = '0;
        end
        else if (acc_shr > (ACC_W-8)'(limit_reg))
        begin
            pid_duty_w = limit_reg;
        end
        else
        begin
            pid_duty_w = acc_shr[14:0];
        end
    end

    assign sat_duty_w = pid_mode ? pid_duty_w : law_duty_reg;

    // working registers carry payload only
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            sample_reg <= adc_sample[SAMPLE_BITS-1:0];
        end
        if (ctl.law_en)
        begin
            meas_reg     <= meas_w;
            err_reg      <= err_w;
            law_duty_reg <= law_duty_w;
        end
        if (ctl.acc_load)
        begin
            acc_reg <= prod_ext;
        end
        else if (ctl.acc_add)
        begin
            acc_reg <= acc_reg + prod_ext;
        end
        else if (ctl.acc_sub)
        begin
            acc_reg <= acc_reg - prod_ext;
        end
        if (ctl.fin)
        begin
            out_duty_reg <= sat_duty_w;
            out_meas_reg <= meas_reg;
        end
    end

    // controller state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_state_reg <= '0;
            integ_reg      <= '0;
            last_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.law_en && pid_mode)
            begin
                integ_reg <= integ_w;
            end
            // derivative term already used the old measurement
            if (ctl.acc_sub)
            begin
                last_reg <= meas_reg;
            end
            if (ctl.fin)
            begin
                duty_state_reg <= sat_duty_w;
                out_valid_reg  <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign duty        = out_duty_reg;
    assign measured_ma = out_meas_reg;

endmodule

// ===== src/lmc_mul.sv =====
`timescale 1ns / 1ps

module lmc_mul
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [lmc_pkg::MUL_A_W-1:0]   a,
    input  logic signed [lmc_pkg::MUL_B_W-1:0]   b,
    output logic signed [lmc_pkg::PROD_W-1:0]    prod
);
    import lmc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== src/lmc_ctrl.sv =====
`timescale 1ns / 1ps

module lmc_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          pid_mode,
    input  logic          out_free,
    output lmc_pkg::ctl_t ctl,
    output logic          idle
);
    import lmc_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL_M = 8'b0000_0010,
        ST_LAW   = 8'b0000_0100,
        ST_MUL_P = 8'b0000_1000,
        ST_MUL_I = 8'b0001_0000,
        ST_MUL_D = 8'b0010_0000,
        ST_ACC_D = 8'b0100_0000,
        ST_SAT   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        ctl          = '0;
        ctl.sel      = OP_MEAS;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL_M;
                end
            end
            ST_MUL_M:
            begin
                ctl.sel    = OP_MEAS;
                ctl.mul_en = 1'b1;
                state_next = ST_LAW;
            end
            ST_LAW:
            begin
                ctl.law_en = 1'b1;
                state_next = pid_mode ? ST_MUL_P : ST_SAT;
            end
            ST_MUL_P:
            begin
                ctl.sel    = OP_P;
                ctl.mul_en = 1'b1;
                state_next = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                ctl.sel      = OP_I;
                ctl.mul_en   = 1'b1;
                ctl.acc_load = 1'b1;
                state_next   = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                ctl.sel     = OP_D;
                ctl.mul_en  = 1'b1;
                ctl.acc_add = 1'b1;
                state_next  = ST_ACC_D;
            end
            ST_ACC_D:
            begin
                ctl.acc_sub = 1'b1;
                state_next  = ST_SAT;
            end
            ST_SAT:
            begin
                // wait here while the previous result is still held
                if (out_free)
                begin
                    ctl.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign idle = (state_reg == ST_IDLE);

endmodule

// ===== src/lmc_chk.sv =====
`timescale 1ns / 1ps

module lmc_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [14:0] duty,
    input logic [15:0] measured_ma
);

    // a stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // a sample beat keeps the block busy for the next cycle
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second sample taken while one is in work");

    // no result rises while a new sample is in the multiply and law states
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid) ##1 !$rose(out_valid))
        else $error("result appeared before the sample was processed");

    // a held result changes neither duty nor current
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(duty) && $stable(measured_ma))
        else $error("stalled result changed");

endmodule

bind led_current_multimode_controller_unit lmc_chk u_lmc_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .duty        (duty),
    .measured_ma (measured_ma)
);

// ===== test/lmc_step_checker.sv =====
`timescale 1ns / 1ps

module lmc_step_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [15:0]                    adc_sample,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [14:0]                    duty,
    input  logic [15:0]                    measured_ma,
    input  logic                           cfg_we,
    input  logic [lmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lmc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             waiting,
    output int                             checked
);
    import lmc_pkg::*;

    typedef struct packed {
        logic [14:0] duty;
        logic [15:0] ma;
    } step_result_t;

    step_result_t predicted_steps[$];

    // shadow copy of the register file
    logic [1:0]  mode_r;
    logic [11:0] setpoint_r;
    logic [14:0] limit_r;
    logic [15:0] sense_r;
    logic [15:0] kp_r;
    logic [15:0] ki_r;
    logic [15:0] kd_r;

    // controller state
    logic [14:0] duty_now;
    int          integ;
    logic [15:0] last_ma;

    task automatic report(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, wanted %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic logic [14:0] clip_to_limit(input longint v);
        longint lim;
        lim = longint'(limit_r);
        if (v < 0)
            return '0;
        if (v > lim)
            return limit_r;
        return v[14:0];
    endfunction

    task automatic advance_controller(input logic [15:0] sample, output step_result_t r);
        logic [31:0] prod;
        logic [15:0] ma;
        int          err;
        int          acc;
        int          lim;
        longint      base;
        longint      kp;
        longint      ki;
        longint      kd;
        longint      ma_l;
        longint      last_l;
        longint      s;
        logic [14:0] nd;
        prod = 32'(sample) * 32'(sense_r);
        ma   = prod[31:16];
        err  = int'(setpoint_r) - int'(ma);
        base = longint'(duty_now);
        case (mode_r)
            MODE_BANG: nd = (ma < 16'(setpoint_r)) ? limit_r : '0;
            MODE_INCR: nd = clip_to_limit((ma < 16'(setpoint_r)) ? base + 10 : base - 10);
            MODE_PROP: nd = clip_to_limit(base + longint'(err));
            default:
            begin
                lim = int'(limit_r);
                acc = integ + err;
                if (acc > lim)
                    acc = lim;
                else if (acc < -lim)
                    acc = -lim;
                integ  = acc;
                kp     = longint'(kp_r);
                ki     = longint'(ki_r);
                kd     = longint'(kd_r);
                ma_l   = longint'(ma);
                last_l = longint'(last_ma);
                // derivative acts on the measurement, not on the error
                s = kp * longint'(err) + ki * longint'(integ) - kd * (ma_l - last_l);
                last_ma = ma;
                nd = (s < 0) ? '0 : clip_to_limit(s / 256);
            end
        endcase
        duty_now = nd;
        r.duty   = nd;
        r.ma     = ma;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        step_result_t r;
        if (!rst_n)
        begin
            mode_r     = MODE_BANG;
            setpoint_r = '0;
            limit_r    = 15'd32767;
            sense_r    = 16'd65535;
            kp_r       = 16'd351;
            ki_r       = 16'd593;
            kd_r       = 16'd259;
            duty_now   = '0;
            integ      = 0;
            last_ma    = '0;
            predicted_steps.delete();
            fail_count = 0;
            checked    = 0;
            waiting   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                checked++;
                if (predicted_steps.size() == 0)
                    report("result beat with nothing pending, duty", int'(duty), -1);
                else
                begin
                    r = predicted_steps.pop_front();
                    if (duty !== r.duty)
                        report("duty", int'(duty), int'(r.duty));
                    if (measured_ma !== r.ma)
                        report("measured_ma", int'(measured_ma), int'(r.ma));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CONTROL_MODE: mode_r     = cfg_data[1:0];
                    REG_SETPOINT_MA:  setpoint_r = cfg_data[11:0];
                    REG_DUTY_LIMIT:   limit_r    = cfg_data[14:0];
                    REG_SENSE_GAIN:   sense_r    = cfg_data;
                    REG_P_GAIN:       kp_r       = cfg_data;
                    REG_I_GAIN:       ki_r       = cfg_data;
                    REG_D_GAIN:       kd_r       = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                advance_controller(adc_sample, r);
                predicted_steps.push_back(r);
            end
            waiting <= predicted_steps.size();
        end
    end

endmodule

// ===== test/tb_led_current_multimode_controller_unit.sv =====
`timescale 1ns / 1ps

module tb_led_current_multimode_controller_unit;
    import lmc_pkg::*;

    // index with no register behind it, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    // a pid step is the longest, leave a little margin after the last beat
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 610;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [15:0]           adc_sample = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [14:0]           duty;
    logic [15:0]           measured_ma;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fails;
    int waiting;
    int checked;

    // idle rates in percent, changed per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int samples_sent  = 0;
    int setting_count = 0;

    always #2 clk = ~clk;

    led_current_multimode_controller_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .adc_sample  (adc_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .duty        (duty),
        .measured_ma (measured_ma),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // watches both channels and the register port, predicts every step
    lmc_step_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .adc_sample  (adc_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .duty        (duty),
        .measured_ma (measured_ma),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fails),
        .waiting     (waiting),
        .checked     (checked)
    );

    // receiver back-pressure, drawn fresh every cycle
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // one sample beat; valid stays up when beats follow back to back
    task automatic send_sample(input logic [15:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        adc_sample <= value;
        do
            @(posedge clk);
        while (in_stall);
        samples_sent++;
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // single register write, with a quiet wait after it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // gains lean toward small values so pid does not always rail
    function automatic logic [15:0] pick_gain();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(1023));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(8191));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // new register setting; upper data bits are random to exercise masking
    task automatic apply_random_setting();
        logic [11:0] sp;
        logic [14:0] lim;
        logic [15:0] sg;
        settle();
        case ($urandom_range(3))
            0:       sp = '0;
            1:       sp = 12'hFFF;
            default: sp = 12'($urandom_range(4095));
        endcase
        case ($urandom_range(5))
            0:       lim = '0;
            1:       lim = 15'h7FFF;
            2:       lim = 15'($urandom_range(15));
            default: lim = 15'($urandom_range(32767));
        endcase
        case ($urandom_range(5))
            0:       sg = '0;
            1:       sg = 16'hFFFF;
            default: sg = 16'($urandom_range(65535));
        endcase
        write_reg(REG_CONTROL_MODE, 16'($urandom_range(65535)));
        write_reg(REG_SETPOINT_MA, {4'($urandom_range(15)), sp});
        write_reg(REG_DUTY_LIMIT, {1'($urandom_range(1)), lim});
        write_reg(REG_SENSE_GAIN, sg);
        write_reg(REG_P_GAIN, pick_gain());
        write_reg(REG_I_GAIN, pick_gain());
        write_reg(REG_D_GAIN, pick_gain());
        if ($urandom_range(7) == 0)
            write_reg(REG_UNUSED, 16'($urandom_range(65535)));
        setting_count++;
    endtask

    // bursts of random samples under changing settings
    task automatic run_phase(input int idle_pct, input int stall_pct);
        int n;
        int burst;
        n = 0;
        settle();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (n < PHASE_ITEMS)
        begin
            apply_random_setting();
            burst = $urandom_range(60, 15);
            repeat (burst) send_sample(pick_sample());
            n += burst;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // bang-bang around the setpoint; setpoint written with high bits set
        write_reg(REG_SETPOINT_MA, 16'hFFFF);
        send_sample(16'd0);
        send_sample(16'hFFFF);
        send_sample(16'd4095);
        send_sample(16'd4096);

        // incremental steps up and down
        settle();
        write_reg(REG_CONTROL_MODE, {14'd0, MODE_INCR});
        send_sample(16'd0);
        send_sample(16'd0);
        send_sample(16'hFFFF);

        // proportional, large positive then large negative error
        settle();
        write_reg(REG_CONTROL_MODE, {14'd0, MODE_PROP});
        send_sample(16'd0);
        send_sample(16'd0);
        send_sample(16'hFFFF);
        send_sample(16'd0);

        // lowered limit saturates the held duty, then zero limit
        settle();
        write_reg(REG_DUTY_LIMIT, 16'd100);
        send_sample(16'd0);
        settle();
        write_reg(REG_DUTY_LIMIT, 16'd0);
        send_sample(16'd0);

        // pid with all gains at full scale; mode and limit written wide
        settle();
        write_reg(REG_DUTY_LIMIT, 16'hFFFF);
        write_reg(REG_P_GAIN, 16'hFFFF);
        write_reg(REG_I_GAIN, 16'hFFFF);
        write_reg(REG_D_GAIN, 16'hFFFF);
        write_reg(REG_CONTROL_MODE, 16'hFFFF);
        send_sample(16'd0);
        send_sample(16'd0);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'd0);

        // zero sense gain and zero gains
        settle();
        write_reg(REG_SENSE_GAIN, 16'd0);
        write_reg(REG_P_GAIN, 16'd0);
        send_sample(16'd1234);
        settle();
        write_reg(REG_I_GAIN, 16'd0);
        write_reg(REG_D_GAIN, 16'd0);
        send_sample(16'hFFFF);

        // integrator is only re-clamped on a pid step
        settle();
        write_reg(REG_SENSE_GAIN, 16'hFFFF);
        write_reg(REG_P_GAIN, 16'd351);
        write_reg(REG_I_GAIN, 16'd593);
        write_reg(REG_D_GAIN, 16'd259);
        write_reg(REG_DUTY_LIMIT, 16'd50);
        write_reg(REG_CONTROL_MODE, {14'd0, MODE_PROP});
        send_sample(16'd0);
        settle();
        write_reg(REG_CONTROL_MODE, {14'd0, MODE_PID});
        send_sample(16'hFFFF);

        // unmapped index must leave everything alone
        settle();
        write_reg(REG_UNUSED, 16'hFFFF);
        send_sample(16'd2000);

        // random part: receiver mostly stalling, then sender mostly idle, then no idling
        run_phase(35, 85);
        run_phase(85, 35);
        run_phase(0, 0);

        settle();
        $display("covered %0d samples under %0d random register settings plus directed cases",
                 samples_sent, setting_count);
        $display("%0d result beats compared, %0d mismatches", checked, fails);
        if (fails == 0 && waiting == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule
